### rtl/no_repeat_max_credit_picker_assert.svh
// Assertion macros for the credit picker top level.
// Depends on nothing; included by the top level only.
`ifndef NO_REPEAT_MAX_CREDIT_PICKER_ASSERT_SVH
`define NO_REPEAT_MAX_CREDIT_PICKER_ASSERT_SVH
// Plain implication checked on every clock edge outside reset.
`define NRP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define NRP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/nrp_pkg.sv
// Shared types and constants for the credit picker.
// No dependencies.
`default_nettype none
package nrp_pkg;
  localparam int unsigned MaxLabelsDef = 16;
  localparam int unsigned CountBitsDef = 16;
  localparam int unsigned LabelW = 5;
  localparam int unsigned StatusW = 3;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_PICK  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_LOADED    = 3'd0,
    ST_PICKED    = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SPOP, S_PRD, S_PCMP, S_PSWRD, S_PSWW, S_PFIN, S_PFINW, S_PPUSH,
    S_SCAN, S_SCANW, S_DEC, S_DECW, S_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // append count from input
    logic clear;      // clear table
    logic sort_init;  // push the whole table range
    logic pop;        // pop range, set j=lo, store=lo
    logic rd_j;       // read entries j and hi
    logic step_j;     // compare result applied, advance j
    logic swap_rd;    // read store and j for exchange
    logic swap_wr;    // write first half of exchange
    logic fin_rd;     // read store and hi for final exchange
    logic push;       // push subranges
    logic set_sorted;
    logic scan_init;
    logic scan_step;
    logic dec_rd;
    logic dec_wr;
    logic wr2;        // second write of an exchange
  } cmd_t;

  typedef struct packed {
    logic full;
    logic few;        // fewer than two entries
    logic sorted;
    logic stack_empty;
    logic lt;         // credit[j] < pivot
    logic j_done;     // j reached hi
    logic scan_done;
    logic found;
  } sts_t;
endpackage
`default_nettype wire

### rtl/nrp_ram.sv
// Generic single-write, dual-read RAM with registered reads.
// No dependencies.
`default_nettype none
module nrp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule
`default_nettype wire

### rtl/nrp_ctrl.sv
// Controller state machine for the credit picker.
// Depends on nrp_pkg.
`default_nettype none
module nrp_ctrl
  import nrp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_fire_i,
  input  wire logic [1:0] kind_i,
  input  wire logic       out_free_i,
  input  wire sts_t       sts_i,
  output cmd_t            cmd_o,
  output logic            busy_o,
  output logic            emit_o,
  output logic [2:0]      status_o
);
  state_e state_q, state_d;
  logic [2:0] status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_LOADED;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o    = '0;
    emit_o   = 1'b0;
    busy_o   = (state_q != S_IDLE);
    status_o = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire_i) begin
          unique case (kind_e'(kind_i))
            KIND_LOAD: begin
              if (sts_i.full) status_d = ST_FULL;
              else begin
                status_d = ST_LOADED;
                cmd_o.load = 1'b1;
              end
              state_d = S_OUT;
            end
            KIND_PICK: begin
              if (sts_i.sorted || sts_i.few) begin
                cmd_o.set_sorted = 1'b1;
                cmd_o.scan_init = 1'b1;
                state_d = S_SCAN;
              end else begin
                cmd_o.sort_init = 1'b1;
                state_d = S_SPOP;
              end
            end
            KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
              status_d = ST_CLEARED;
              state_d = S_OUT;
            end
            KIND_NONE: state_d = S_IDLE;
          endcase
        end
      end
      S_SPOP: begin
        if (sts_i.stack_empty) begin
          cmd_o.set_sorted = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d = S_SCAN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = S_PRD;
        end
      end
      S_PRD: begin
        if (sts_i.j_done) begin
          cmd_o.fin_rd = 1'b1;
          state_d = S_PFIN;
        end else begin
          cmd_o.rd_j = 1'b1;
          state_d = S_PCMP;
        end
      end
      S_PCMP: begin
        if (sts_i.lt) begin
          cmd_o.swap_rd = 1'b1;
          state_d = S_PSWRD;
        end else begin
          cmd_o.step_j = 1'b1;
          state_d = S_PRD;
        end
      end
      S_PSWRD: begin
        cmd_o.swap_wr = 1'b1;
        state_d = S_PSWW;
      end
      S_PSWW: begin
        cmd_o.wr2 = 1'b1;
        cmd_o.step_j = 1'b1;
        state_d = S_PRD;
      end
      S_PFIN: begin
        cmd_o.swap_wr = 1'b1;
        state_d = S_PFINW;
      end
      S_PFINW: begin
        cmd_o.wr2 = 1'b1;
        state_d = S_PPUSH;
      end
      S_PPUSH: begin
        cmd_o.push = 1'b1;
        state_d = S_SPOP;
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          if (sts_i.found) begin
            cmd_o.dec_rd = 1'b1;
            state_d = S_DEC;
          end else begin
            status_d = ST_EXHAUSTED;
            state_d = S_OUT;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d = S_SCANW;
        end
      end
      S_SCANW: state_d = S_SCAN;
      S_DEC: begin
        // The chosen index has settled by now, so the entry is read again here.
        cmd_o.dec_rd = 1'b1;
        state_d = S_DECW;
      end
      S_DECW: begin
        cmd_o.dec_wr = 1'b1;
        status_d = ST_PICKED;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free_i) begin
          emit_o = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### rtl/nrp_dpath.sv
// Datapath for the credit picker: tables, sort range stack and pick scan.
// Depends on nrp_pkg and nrp_ram.
`default_nettype none
module nrp_dpath
  import nrp_pkg::*;
#(
  parameter int unsigned MaxLabels = MaxLabelsDef,
  parameter int unsigned CountBits = CountBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  input  wire logic [15:0]          count_i,
  output sts_t                      sts_o,
  output logic [LabelW-1:0]         label_o
);
  localparam int unsigned AW = $clog2(MaxLabels);
  localparam int unsigned NW = $clog2(MaxLabels + 1);
  localparam int unsigned EW = CountBits + LabelW;

  logic [NW-1:0] loaded_q;
  logic [LabelW-1:0] last_q;
  logic sorted_q;
  // Range stack holds at most MaxLabels/2 disjoint ranges.
  logic [AW-1:0] stk_lo_q [MaxLabels];
  logic [AW-1:0] stk_hi_q [MaxLabels];
  logic [NW-1:0] top_q;
  logic [AW-1:0] lo_q, hi_q, j_q, st_q;
  logic [AW-1:0] ra_q, rb_q;   // addresses of pending exchange
  logic [EW-1:0] hold_q;
  logic [NW-1:0] sj_q;         // scan index, also lag for read
  logic [AW-1:0] best_q;
  logic [CountBits-1:0] bestc_q;
  logic found_q, scan_rd_q;
  logic [AW-1:0] nzidx_q;
  logic nz_q;

  logic we;
  logic [AW-1:0] waddr, ra, rb;
  logic [EW-1:0] wdata, rda, rdb;
  logic [CountBits-1:0] ca, cb;
  logic [LabelW-1:0] la;

  nrp_ram #(.Width(EW), .Depth(MaxLabels)) u_tab (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(ra), .raddr_b_i(rb), .rdata_a_o(rda), .rdata_b_o(rdb)
  );
  assign ca = rda[EW-1:LabelW];
  assign la = rda[LabelW-1:0];
  assign cb = rdb[EW-1:LabelW];

  always_comb begin
    ra = j_q;
    rb = hi_q;
    if (cmd_i.swap_rd) begin ra = st_q; rb = j_q; end
    if (cmd_i.fin_rd) begin ra = st_q; rb = hi_q; end
    if (cmd_i.scan_step) ra = sj_q[AW-1:0];
    if (cmd_i.dec_rd) ra = best_q;
    we = 1'b0;
    waddr = ra_q;
    wdata = rdb;
    if (cmd_i.load) begin
      we = 1'b1;
      waddr = loaded_q[AW-1:0];
      wdata = {CountBits'(count_i), LabelW'(loaded_q + NW'(1))};
    end else if (cmd_i.swap_wr) begin
      we = 1'b1;
    end else if (cmd_i.wr2) begin
      we = 1'b1;
      waddr = rb_q;
      wdata = hold_q;
    end else if (cmd_i.dec_wr) begin
      we = 1'b1;
      waddr = best_q;
      wdata = {ca - CountBits'(1), la};
    end
  end

  logic [AW:0] st_inc;
  assign st_inc = {1'b0, st_q} + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      last_q <= '0;
      sorted_q <= 1'b0;
      top_q <= '0;
      found_q <= 1'b0;
      scan_rd_q <= 1'b0;
      nz_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        loaded_q <= loaded_q + NW'(1);
        sorted_q <= 1'b0;
      end
      if (cmd_i.clear) begin
        loaded_q <= '0;
        last_q <= '0;
        sorted_q <= 1'b0;
      end
      if (cmd_i.set_sorted) sorted_q <= 1'b1;
      if (cmd_i.sort_init) begin
        stk_lo_q[0] <= '0;
        stk_hi_q[0] <= AW'(loaded_q - NW'(1));
        top_q <= NW'(1);
      end
      if (cmd_i.pop) begin
        lo_q <= stk_lo_q[AW'(top_q - NW'(1))];
        hi_q <= stk_hi_q[AW'(top_q - NW'(1))];
        j_q  <= stk_lo_q[AW'(top_q - NW'(1))];
        st_q <= stk_lo_q[AW'(top_q - NW'(1))];
        top_q <= top_q - NW'(1);
      end
      if (cmd_i.swap_rd || cmd_i.fin_rd) begin
        ra_q <= ra;
        rb_q <= rb;
      end
      if (cmd_i.swap_wr) hold_q <= rda;
      if (cmd_i.step_j) j_q <= j_q + AW'(1);
      if (cmd_i.wr2 && !cmd_i.step_j) begin
        // Final exchange done: pivot sits at st_q.
      end
      if (cmd_i.wr2 && cmd_i.step_j) st_q <= st_q + AW'(1);
      if (cmd_i.push) begin
        if ({1'b0, st_q} > {1'b0, lo_q} + 1'b1) begin
          stk_lo_q[AW'(top_q)] <= lo_q;
          stk_hi_q[AW'(top_q)] <= st_q - AW'(1);
          if (st_inc < {1'b0, hi_q}) begin
            stk_lo_q[AW'(top_q + NW'(1))] <= st_inc[AW-1:0];
            stk_hi_q[AW'(top_q + NW'(1))] <= hi_q;
            top_q <= top_q + NW'(2);
          end else top_q <= top_q + NW'(1);
        end else if (st_inc < {1'b0, hi_q}) begin
          stk_lo_q[AW'(top_q)] <= st_inc[AW-1:0];
          stk_hi_q[AW'(top_q)] <= hi_q;
          top_q <= top_q + NW'(1);
        end
      end
      if (cmd_i.scan_init) begin
        sj_q <= '0;
        found_q <= 1'b0;
        nz_q <= 1'b0;
        scan_rd_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        sj_q <= sj_q + NW'(1);
        scan_rd_q <= 1'b1;
        best_q <= best_q;
      end else if (scan_rd_q) begin
        scan_rd_q <= 1'b0;
        if (ca != '0) begin
          if (!nz_q) begin
            nz_q <= 1'b1;
            nzidx_q <= AW'(sj_q - NW'(1));
          end
          if (la != last_q && (!found_q || ca > bestc_q)) begin
            found_q <= 1'b1;
            best_q <= AW'(sj_q - NW'(1));
            bestc_q <= ca;
          end
        end
      end
      if (cmd_i.dec_rd && !found_q) best_q <= nzidx_q;
      if (cmd_i.dec_wr) last_q <= la;
    end
  end

  // A fallback pick reads the first nonzero entry; dec_rd picks the address.
  assign sts_o.full        = (loaded_q >= NW'(MaxLabels));
  assign sts_o.few         = (loaded_q < NW'(2));
  assign sts_o.sorted      = sorted_q;
  assign sts_o.stack_empty = (top_q == '0);
  assign sts_o.lt          = (ca < cb);
  assign sts_o.j_done      = (j_q == hi_q);
  assign sts_o.scan_done   = (sj_q == loaded_q) && !scan_rd_q;
  assign sts_o.found       = found_q || nz_q;
  assign label_o           = last_q;
endmodule
`default_nettype wire

### rtl/no_repeat_max_credit_picker.sv
// Top level of the credit picker: stream ports, controller and datapath.
// Depends on nrp_pkg, nrp_ctrl, nrp_dpath and the assertion header.
`default_nettype none
// Each beat in gives one beat out, except kind 3, which gives none. A pick
// scans the table entry by entry. The first pick after a load also runs a
// quicksort over the table RAM first, if two or more entries are loaded;
// the table RAM has two read ports and one write port, so each exchange is
// written in two halves. One item is in work at a time; a result held by
// the receiver stalls the input.
`include "no_repeat_max_credit_picker_assert.svh"
module no_repeat_max_credit_picker
  import nrp_pkg::*;
#(
  parameter int unsigned MAX_LABELS = MaxLabelsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,  // count[15:0]
  input  wire logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o   // label[4:0], status[7:5]
);
  cmd_t cmd;
  sts_t sts;
  logic busy, emit, in_fire, out_free;
  logic [2:0] status;
  logic [LabelW-1:0] last_lbl;
  logic ovalid_q;
  logic [7:0] odata_q;

  assign s_axis_tready_o = !busy;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;

  nrp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .kind_i(s_axis_tuser_i),
    .out_free_i(out_free), .sts_i(sts), .cmd_o(cmd), .busy_o(busy),
    .emit_o(emit), .status_o(status)
  );

  nrp_dpath #(.MaxLabels(MAX_LABELS), .CountBits(COUNT_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .count_i(s_axis_tdata_i),
    .sts_o(sts), .label_o(last_lbl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (emit) ovalid_q <= 1'b1;
    else if (m_axis_tready_i) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (emit) odata_q <= {status, (status == ST_PICKED) ? last_lbl : LabelW'(0)};
  end
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

  `NRP_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, busy, !in_fire)
  `NRP_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, emit, m_axis_tvalid_o)
  `NRP_ASSERT_IMP(a_emit_room, clk_i, rst_ni, emit, out_free)
endmodule
`default_nettype wire

### tb/no_repeat_max_credit_picker_tb.sv
// Self-checking testbench for the no-repeat maximum credit picker.
// Depends on nrp_pkg and the no_repeat_max_credit_picker top level.
`timescale 1ns / 100ps
module no_repeat_max_credit_picker_tb;
  import nrp_pkg::*;

  localparam int unsigned NLAB = 16;
  localparam int unsigned WDOG_LIMIT = 40000;
  localparam int unsigned N_RANDOM = 525;

  typedef struct packed {
    logic [4:0] label;
    status_e    status;
  } pick_res_t;

  typedef struct {
    kind_e       kind;
    logic [15:0] count;
    logic        known;
    pick_res_t   res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = KIND_NONE;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [7:0] m_axis_tdata_o;

  always #2 clk_i = ~clk_i;

  no_repeat_max_credit_picker u_top (
    .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i,
    .s_axis_tuser_i, .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  // Predictor state.
  logic [15:0] credit_q [NLAB];
  logic [4:0]  lab_q [NLAB];
  int unsigned n_loaded;
  logic [4:0]  prev_label;
  bit          is_sorted;

  pick_res_t   pending_res[$];
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  bit          rx_hold = 1'b0;
  bit          stim_done = 1'b0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH %s: got %02h expected %02h at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic void swap_entries(int unsigned x, int unsigned y);
    logic [15:0] c;
    logic [4:0] l;
    c = credit_q[x]; l = lab_q[x];
    credit_q[x] = credit_q[y]; lab_q[x] = lab_q[y];
    credit_q[y] = c; lab_q[y] = l;
  endfunction

  // Lomuto quicksort on an explicit stack of ranges, as the block does it.
  function automatic void sort_credits();
    int unsigned lo_s [NLAB];
    int unsigned hi_s [NLAB];
    int unsigned sp, lo, hi, st;
    sp = 0;
    if (n_loaded < 2) return;
    lo_s[0] = 0; hi_s[0] = n_loaded - 1; sp = 1;
    while (sp > 0) begin
      sp--;
      lo = lo_s[sp]; hi = hi_s[sp];
      st = lo;
      for (int unsigned j = lo; j < hi; j++) begin
        if (credit_q[j] < credit_q[hi]) begin
          swap_entries(st, j);
          st++;
        end
      end
      swap_entries(st, hi);
      if (st > lo + 1 && sp < NLAB) begin
        lo_s[sp] = lo; hi_s[sp] = st - 1; sp++;
      end
      if (st + 1 < hi && sp < NLAB) begin
        lo_s[sp] = st + 1; hi_s[sp] = hi; sp++;
      end
    end
  endfunction

  function automatic bit predict_pick(input kind_e kind, input logic [15:0] count,
                                      output pick_res_t res);
    int best;
    best = -1;
    res.label = '0;
    case (kind)
      KIND_LOAD: begin
        if (n_loaded >= NLAB) begin
          res.status = ST_FULL;
        end else begin
          credit_q[n_loaded] = count;
          lab_q[n_loaded] = 5'(n_loaded + 1);
          n_loaded++;
          is_sorted = 1'b0;
          res.status = ST_LOADED;
        end
      end
      KIND_PICK: begin
        if (!is_sorted) begin
          sort_credits();
          is_sorted = 1'b1;
        end
        for (int j = 0; j < int'(n_loaded); j++) begin
          if (credit_q[j] != 0 && lab_q[j] != prev_label)
            if (best < 0 || credit_q[j] > credit_q[best]) best = j;
        end
        if (best < 0) begin
          for (int j = 0; j < int'(n_loaded); j++) begin
            if (best < 0 && credit_q[j] != 0) best = j;
          end
        end
        if (best >= 0) begin
          credit_q[best]--;
          prev_label = lab_q[best];
          res.label = prev_label;
          res.status = ST_PICKED;
        end else begin
          res.status = ST_EXHAUSTED;
        end
      end
      KIND_CLEAR: begin
        n_loaded = 0;
        prev_label = '0;
        is_sorted = 1'b0;
        res.status = ST_CLEARED;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // Sender: offers one beat, waits for acceptance, predicts the result.
  // Valid stays up after a beat and only drops when a gap is drawn or on a drain.
  task automatic send_beat(input kind_e kind, input logic [15:0] count, input bit gaps,
                           input bit known, input pick_res_t want);
    pick_res_t res;
    int unsigned gap;
    gap = gaps ? $urandom_range(6, 0) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= kind;
    s_axis_tdata_i <= count;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_pick(kind, count, res)) begin
      if (known && res !== want)
        report_mismatch("table row", {res.label, res.status}, {want.label, want.status});
      pending_res.push_back(res);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  // Random run: mostly picks, some loads, now and then a clear or an idle beat.
  task automatic random_phase(input int unsigned n_items);
    int unsigned sent, r;
    logic [15:0] c;
    kind_e k;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99, 0);
      if (n_loaded == 0 || r < 30) begin
        k = KIND_LOAD;
        case ($urandom_range(4, 0))
          0: c = 16'hFFFF;
          1: c = 16'($urandom);
          default: c = 16'($urandom_range(4, 0));
        endcase
      end else if (r < 94) begin
        k = KIND_PICK; c = 16'($urandom);
      end else if (r < 98) begin
        k = KIND_CLEAR; c = 16'($urandom);
      end else begin
        k = KIND_NONE; c = 16'($urandom);
      end
      send_beat(k, c, 1'b1, 1'b0, '0);
      if (k != KIND_NONE) sent++;
    end
  endtask

  stim_row_t dir_rows[$];

  task automatic add_row(kind_e k, logic [15:0] c, bit kn, logic [4:0] l, status_e s);
    stim_row_t row;
    row.kind = k; row.count = c; row.known = kn;
    row.res.label = l; row.res.status = s;
    dir_rows.push_back(row);
  endtask

  initial begin
    n_loaded = 0; prev_label = '0; is_sorted = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(KIND_PICK,  16'h0000, 1'b1, 5'd0, ST_EXHAUSTED);
    add_row(KIND_NONE,  16'hFFFF, 1'b0, 5'd0, ST_LOADED);
    add_row(KIND_LOAD,  16'hFFFF, 1'b1, 5'd0, ST_LOADED);
    add_row(KIND_PICK,  16'h0000, 1'b1, 5'd1, ST_PICKED);
    add_row(KIND_PICK,  16'h0000, 1'b1, 5'd1, ST_PICKED);
    add_row(KIND_LOAD,  16'h0000, 1'b1, 5'd0, ST_LOADED);
    add_row(KIND_LOAD,  16'h0003, 1'b1, 5'd0, ST_LOADED);
    add_row(KIND_LOAD,  16'h0003, 1'b1, 5'd0, ST_LOADED);
    add_row(KIND_PICK,  16'h0000, 1'b0, 5'd0, ST_LOADED);
    add_row(KIND_PICK,  16'h0000, 1'b0, 5'd0, ST_LOADED);
    add_row(KIND_LOAD,  16'h0001, 1'b1, 5'd0, ST_LOADED);
    add_row(KIND_PICK,  16'h0000, 1'b0, 5'd0, ST_LOADED);
    add_row(KIND_CLEAR, 16'hFFFF, 1'b1, 5'd0, ST_CLEARED);
    add_row(KIND_PICK,  16'h0000, 1'b1, 5'd0, ST_EXHAUSTED);
    for (int i = 0; i < 16; i++) add_row(KIND_LOAD, 16'(i * 4099), 1'b1, 5'd0, ST_LOADED);
    add_row(KIND_LOAD,  16'h5555, 1'b1, 5'd0, ST_FULL);
    add_row(KIND_PICK,  16'h0000, 1'b0, 5'd0, ST_LOADED);
    add_row(KIND_CLEAR, 16'h0000, 1'b1, 5'd0, ST_CLEARED);
    add_row(KIND_LOAD,  16'h0000, 1'b1, 5'd0, ST_LOADED);
    add_row(KIND_PICK,  16'h0000, 1'b1, 5'd0, ST_EXHAUSTED);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].kind, dir_rows[i].count, 1'b0, dir_rows[i].known,
                dir_rows[i].res);

    random_phase(N_RANDOM / 2);
    // Pause until everything is out, then let the receiver stall for long.
    wait_drained();
    rx_hold = 1'b1;
    random_phase(30);
    rx_hold = 1'b0;
    random_phase(N_RANDOM - N_RANDOM / 2 - 30);
    wait_drained();
    repeat (200) @(posedge clk_i);
    stim_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    int unsigned stall;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold && !held) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
      end
      stall = $urandom_range(6, 0);
      if ($urandom_range(7, 0) == 0) stall = 0;
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  // Result checker and watchdog.
  always @(posedge clk_i) begin
    pick_res_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_res.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata_o, 8'h00);
        end else begin
          want = pending_res.pop_front();
          if (m_axis_tdata_o[4:0] !== want.label)
            report_mismatch("label", {3'b0, m_axis_tdata_o[4:0]}, {3'b0, want.label});
          if (m_axis_tdata_o[7:5] !== want.status)
            report_mismatch("status", {5'b0, m_axis_tdata_o[7:5]}, {5'b0, want.status});
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    wait (stim_done);
    if (n_errors == 0 && pending_res.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
